// ----- sv/rdmp_pkg.sv -----
// Shared constants, register codes and types of the radial distortion point mapper.
package rdmp_pkg;

	localparam int COORD_BITS_DEF = 13;
	localparam int K1_FRAC_DEF    = 40;
	localparam int K2_FRAC_DEF    = 64;

	localparam int COEFF_BITS  = 32;
	localparam int CENTER_BITS = 12;
	localparam int DEST_BITS   = 15;

	// factor: signed, FACT_FRAC fractional bits; each term saturates at 2^60
	localparam int          FACT_FRAC  = 32;
	localparam int          FACT_BITS  = 63;
	localparam int          TERM_BITS  = 61;
	localparam logic [63:0] TERM_LIMIT = 64'd1 << 60;

	// 0.3 in Q0.32
	localparam int                 PT_BITS     = 31;
	localparam logic [PT_BITS-1:0] POINT_THREE = 31'd1288490189;

	// quotient saturates at 2^Q_BITS
	localparam int Q_BITS     = 20;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = Q_BITS / DIV_STEPS;
	localparam int LATENCY    = DIV_STAGES + 8;

	localparam logic signed [DEST_BITS-1:0] DEST_MAX = {1'b0, {(DEST_BITS-1){1'b1}}};
	localparam logic signed [DEST_BITS-1:0] DEST_MIN = {1'b1, {(DEST_BITS-1){1'b0}}};

	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_K1   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_K2   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_USE_SECOND = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_ROW = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_COL = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HH     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HW     = 3'd6;

	typedef struct packed {
		logic fpos;
		logic neg_row;
		logic neg_col;
	} rdmp_side_t;

endpackage

// ----- sv/radial_distortion_map_point_unit.sv -----
// Radial distortion forward map of one pixel coordinate, k1 and optional k2 terms.
//
//  channel   signals                                        handshake
//  config    cfg_we, cfg_index, cfg_wdata                    write when cfg_we
//  input     pixel_row, pixel_col                            start && !busy
//  result    dest_row, dest_col, src_row_value,              done, one cycle
//            src_col_value, in_frame
//
// One beat in per clock; busy stays low. Each result passes through six stages for
// offsets, r2, the two coefficient products and the factor sum, ten stages of the
// shared two-bit-per-stage divider and two for placement. Reset clears the valid
// bits and the configuration registers; there is no clearing pass.
// Results cannot be held off; the pipeline never stalls.
module radial_distortion_map_point_unit #(
	parameter int COORD_BITS   = rdmp_pkg::COORD_BITS_DEF,
	parameter int K1_FRAC_BITS = rdmp_pkg::K1_FRAC_DEF,
	parameter int K2_FRAC_BITS = rdmp_pkg::K2_FRAC_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rdmp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [rdmp_pkg::COEFF_BITS-1:0]       cfg_wdata,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [COORD_BITS-1:0]                 pixel_row,
	input  logic [COORD_BITS-1:0]                 pixel_col,
	output logic                                  done,
	output logic signed [rdmp_pkg::DEST_BITS-1:0] dest_row,
	output logic signed [rdmp_pkg::DEST_BITS-1:0] dest_col,
	output logic [COORD_BITS-1:0]                 src_row_value,
	output logic [COORD_BITS-1:0]                 src_col_value,
	output logic                                  in_frame
);
	import rdmp_pkg::*;

	localparam int MAG_BITS = (COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS;
	localparam int DIFF_BITS = MAG_BITS + 1;
	localparam int R2_BITS  = 2 * MAG_BITS + 1;
	localparam int NUM_BITS = MAG_BITS + PT_BITS;
	localparam int DEN_BITS = NUM_BITS + 1;
	localparam int P_BITS   = COEFF_BITS + R2_BITS;
	localparam int HI_BITS  = 2 * R2_BITS;
	localparam int PL_BITS  = Q_BITS + 3;
	localparam int K1_SH    = K1_FRAC_BITS - FACT_FRAC;
	localparam int K2_SH    = K2_FRAC_BITS - FACT_FRAC;
	localparam int PASS_BITS = 2 * COORD_BITS;

	// configuration
	logic signed [COEFF_BITS-1:0] k1_q, k2_q;
	logic                         use2_q;
	logic [CENTER_BITS-1:0]       crow_q, ccol_q, hh_q, hw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q   <= '0;
			k2_q   <= '0;
			use2_q <= 1'b0;
			crow_q <= '0;
			ccol_q <= '0;
			hh_q   <= '0;
			hw_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEFF_K1:   k1_q   <= cfg_wdata;
				REG_COEFF_K2:   k2_q   <= cfg_wdata;
				REG_USE_SECOND: use2_q <= cfg_wdata[0];
				REG_CENTER_ROW: crow_q <= cfg_wdata[CENTER_BITS-1:0];
				REG_CENTER_COL: ccol_q <= cfg_wdata[CENTER_BITS-1:0];
				REG_OUT_HH:     hh_q   <= cfg_wdata[CENTER_BITS-1:0];
				REG_OUT_HW:     hw_q   <= cfg_wdata[CENTER_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// s1: offsets from center, magnitude and sign
	logic [DIFF_BITS-1:0] dy, dx;
	assign dy = DIFF_BITS'(pixel_row) - DIFF_BITS'(crow_q);
	assign dx = DIFF_BITS'(pixel_col) - DIFF_BITS'(ccol_q);

	logic                  v_s1, neg_row_s1, neg_col_s1;
	logic [MAG_BITS-1:0]   mag_row_s1, mag_col_s1;
	logic [COORD_BITS-1:0] prow_s1, pcol_s1;

	// s2: r2 and 0.3*|d|
	logic                  v_s2, neg_row_s2, neg_col_s2;
	logic [R2_BITS-1:0]    r2_s2;
	logic [NUM_BITS-1:0]   num_row_s2, num_col_s2;
	logic [COORD_BITS-1:0] prow_s2, pcol_s2;

	// s3: |k1|*r2, |k2|*r2
	logic                  v_s3, neg_row_s3, neg_col_s3;
	logic [R2_BITS-1:0]    r2_s3;
	logic [P_BITS-1:0]     p1_s3, a_s3;
	logic [NUM_BITS-1:0]   num_row_s3, num_col_s3;
	logic [COORD_BITS-1:0] prow_s3, pcol_s3;

	// s4: k1 term scaled, k2 partial products
	logic                  v_s4, neg_row_s4, neg_col_s4;
	logic [TERM_BITS-1:0]  t1_s4;
	logic [P_BITS-1:0]     lo_s4;
	logic [HI_BITS-1:0]    hi_s4;
	logic [NUM_BITS-1:0]   num_row_s4, num_col_s4;
	logic [COORD_BITS-1:0] prow_s4, pcol_s4;

	// s5: signed terms
	logic                  v_s5, neg_row_s5, neg_col_s5;
	logic [FACT_BITS-1:0]  t1s_s5, t2s_s5;
	logic [NUM_BITS-1:0]   num_row_s5, num_col_s5;
	logic [COORD_BITS-1:0] prow_s5, pcol_s5;

	// s6: factor, divisor
	logic                  v_s6;
	rdmp_side_t            side_s6;
	logic [DEN_BITS-1:0]   den_s6;
	logic [NUM_BITS-1:0]   num_row_s6, num_col_s6;
	logic [COORD_BITS-1:0] prow_s6, pcol_s6;

	logic [COEFF_BITS-1:0] k1_abs, k2_abs;
	assign k1_abs = k1_q[COEFF_BITS-1] ? -k1_q : k1_q;
	assign k2_abs = k2_q[COEFF_BITS-1] ? -k2_q : k2_q;

	logic [TERM_BITS-1:0] t1_nxt, t2_nxt;

	if (K1_SH >= 0) begin : g_k1_down
		always_comb begin
			logic [63:0] p;
			p = 64'(p1_s3) >> K1_SH;
			t1_nxt = (p > TERM_LIMIT) ? TERM_LIMIT[TERM_BITS-1:0] : p[TERM_BITS-1:0];
		end
	end else begin : g_k1_up
		always_comb begin
			logic [63:0] p;
			p = 64'(p1_s3);
			if (p > (TERM_LIMIT >> (-K1_SH))) begin
				t1_nxt = TERM_LIMIT[TERM_BITS-1:0];
			end else begin
				t1_nxt = TERM_BITS'(p << (-K1_SH));
			end
		end
	end

	if (K2_SH <= 32) begin : g_k2_low
		always_comb begin
			logic [63:0] part;
			logic [63:0] v;
			part = 64'(lo_s4) >> K2_SH;
			if (64'(hi_s4) > (TERM_LIMIT >> (32 - K2_SH))) begin
				v = TERM_LIMIT;
			end else begin
				v = (64'(hi_s4) << (32 - K2_SH)) + part;
			end
			t2_nxt = (v > TERM_LIMIT) ? TERM_LIMIT[TERM_BITS-1:0] : v[TERM_BITS-1:0];
		end
	end else begin : g_k2_high
		always_comb begin
			logic [63:0] v;
			v = (64'(hi_s4) + (64'(lo_s4) >> 32)) >> (K2_SH - 32);
			t2_nxt = (v > TERM_LIMIT) ? TERM_LIMIT[TERM_BITS-1:0] : v[TERM_BITS-1:0];
		end
	end

	logic [FACT_BITS-1:0] fact;
	logic                 fpos, fbig;
	assign fact = (FACT_BITS'(1) << FACT_FRAC) + t1s_s5 + t2s_s5;
	assign fpos = !fact[FACT_BITS-1] && (|fact);
	assign fbig = |fact[FACT_BITS-1:NUM_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		neg_row_s1 <= dy[DIFF_BITS-1];
		neg_col_s1 <= dx[DIFF_BITS-1];
		mag_row_s1 <= dy[DIFF_BITS-1] ? MAG_BITS'(-dy) : dy[MAG_BITS-1:0];
		mag_col_s1 <= dx[DIFF_BITS-1] ? MAG_BITS'(-dx) : dx[MAG_BITS-1:0];
		prow_s1    <= pixel_row;
		pcol_s1    <= pixel_col;

		neg_row_s2 <= neg_row_s1;
		neg_col_s2 <= neg_col_s1;
		r2_s2      <= R2_BITS'(mag_row_s1) * R2_BITS'(mag_row_s1)
			+ R2_BITS'(mag_col_s1) * R2_BITS'(mag_col_s1);
		num_row_s2 <= NUM_BITS'(mag_row_s1) * NUM_BITS'(POINT_THREE);
		num_col_s2 <= NUM_BITS'(mag_col_s1) * NUM_BITS'(POINT_THREE);
		prow_s2    <= prow_s1;
		pcol_s2    <= pcol_s1;

		neg_row_s3 <= neg_row_s2;
		neg_col_s3 <= neg_col_s2;
		r2_s3      <= r2_s2;
		p1_s3      <= P_BITS'(k1_abs) * P_BITS'(r2_s2);
		a_s3       <= P_BITS'(k2_abs) * P_BITS'(r2_s2);
		num_row_s3 <= num_row_s2;
		num_col_s3 <= num_col_s2;
		prow_s3    <= prow_s2;
		pcol_s3    <= pcol_s2;

		neg_row_s4 <= neg_row_s3;
		neg_col_s4 <= neg_col_s3;
		t1_s4      <= t1_nxt;
		lo_s4      <= P_BITS'(a_s3[31:0]) * P_BITS'(r2_s3);
		hi_s4      <= HI_BITS'(a_s3[P_BITS-1:32]) * HI_BITS'(r2_s3);
		num_row_s4 <= num_row_s3;
		num_col_s4 <= num_col_s3;
		prow_s4    <= prow_s3;
		pcol_s4    <= pcol_s3;

		neg_row_s5 <= neg_row_s4;
		neg_col_s5 <= neg_col_s4;
		t1s_s5     <= k1_q[COEFF_BITS-1] ? -FACT_BITS'(t1_s4) : FACT_BITS'(t1_s4);
		if (!use2_q) begin
			t2s_s5 <= '0;
		end else begin
			t2s_s5 <= k2_q[COEFF_BITS-1] ? -FACT_BITS'(t2_nxt) : FACT_BITS'(t2_nxt);
		end
		num_row_s5 <= num_row_s4;
		num_col_s5 <= num_col_s4;
		prow_s5    <= prow_s4;
		pcol_s5    <= pcol_s4;

		side_s6.fpos    <= fpos;
		side_s6.neg_row <= neg_row_s5;
		side_s6.neg_col <= neg_col_s5;
		priority if (!fpos) begin
			den_s6 <= DEN_BITS'(1);
		end else if (fbig) begin
			den_s6 <= {1'b1, {NUM_BITS{1'b0}}};
		end else begin
			den_s6 <= {1'b0, fact[NUM_BITS-1:0]};
		end
		num_row_s6 <= num_row_s5;
		num_col_s6 <= num_col_s5;
		prow_s6    <= prow_s5;
		pcol_s6    <= pcol_s5;
	end

	// divider
	logic                 dv_valid;
	rdmp_side_t           dv_side;
	logic [PASS_BITS-1:0] dv_pass;
	logic [Q_BITS:0]      dv_quo_row, dv_ceil_row, dv_quo_col, dv_ceil_col;

	rdmp_divider #(
		.NUM_BITS  (NUM_BITS),
		.DEN_BITS  (DEN_BITS),
		.PASS_BITS (PASS_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_side   (side_s6),
		.in_pass   ({prow_s6, pcol_s6}),
		.num_row   (num_row_s6),
		.num_col   (num_col_s6),
		.den       (den_s6),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_pass  (dv_pass),
		.quo_row   (dv_quo_row),
		.ceil_row  (dv_ceil_row),
		.quo_col   (dv_quo_col),
		.ceil_col  (dv_ceil_col)
	);

	// truncation toward zero of h +/- n/factor
	function automatic logic signed [PL_BITS-1:0] place(
		input logic                   neg,
		input logic [CENTER_BITS-1:0] h,
		input logic [Q_BITS:0]        q,
		input logic [Q_BITS:0]        c
	);
		logic signed [PL_BITS-1:0] hs, qs, cs;
		hs = PL_BITS'(h);
		qs = PL_BITS'(q);
		cs = PL_BITS'(c);
		priority if (!neg) begin
			place = hs + qs;
		end else if (cs <= hs) begin
			place = hs - cs;
		end else begin
			place = hs - qs;
		end
	endfunction

	function automatic logic signed [DEST_BITS-1:0] clamp(input logic signed [PL_BITS-1:0] r);
		priority if (r > PL_BITS'(DEST_MAX)) begin
			clamp = DEST_MAX;
		end else if (r < PL_BITS'(DEST_MIN)) begin
			clamp = DEST_MIN;
		end else begin
			clamp = r[DEST_BITS-1:0];
		end
	endfunction

	// s7 and s8 follow the divider
	logic                      v_s7, fpos_s7;
	logic signed [PL_BITS-1:0] drow_s7, dcol_s7;
	logic [COORD_BITS-1:0]     prow_s7, pcol_s7;

	logic                         v_s8, in_frame_s8;
	logic signed [DEST_BITS-1:0]  drow_s8, dcol_s8;
	logic [COORD_BITS-1:0]        prow_s8, pcol_s8;

	logic frame_hit;
	assign frame_hit = fpos_s7
		&& !drow_s7[PL_BITS-1] && (drow_s7 < PL_BITS'({hh_q, 1'b0}))
		&& !dcol_s7[PL_BITS-1] && (dcol_s7 < PL_BITS'({hw_q, 1'b0}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s7 <= dv_valid;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		fpos_s7 <= dv_side.fpos;
		drow_s7 <= place(dv_side.neg_row, hh_q, dv_quo_row, dv_ceil_row);
		dcol_s7 <= place(dv_side.neg_col, hw_q, dv_quo_col, dv_ceil_col);
		prow_s7 <= dv_pass[PASS_BITS-1:COORD_BITS];
		pcol_s7 <= dv_pass[COORD_BITS-1:0];

		drow_s8     <= fpos_s7 ? clamp(drow_s7) : '0;
		dcol_s8     <= fpos_s7 ? clamp(dcol_s7) : '0;
		in_frame_s8 <= frame_hit;
		prow_s8     <= prow_s7;
		pcol_s8     <= pcol_s7;
	end

	assign done          = v_s8;
	assign dest_row      = drow_s8;
	assign dest_col      = dcol_s8;
	assign src_row_value = prow_s8;
	assign src_col_value = pcol_s8;
	assign in_frame      = in_frame_s8;

endmodule

// ----- sv/rdmp_divider.sv -----
// Pipelined restoring divider: two dividends over one shared divisor, saturating quotients.
module rdmp_divider #(
	parameter int NUM_BITS  = 44,
	parameter int DEN_BITS  = 45,
	parameter int PASS_BITS = 2 * rdmp_pkg::COORD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  rdmp_pkg::rdmp_side_t     in_side,
	input  logic [PASS_BITS-1:0]     in_pass,
	input  logic [NUM_BITS-1:0]      num_row,
	input  logic [NUM_BITS-1:0]      num_col,
	input  logic [DEN_BITS-1:0]      den,
	output logic                     out_valid,
	output rdmp_pkg::rdmp_side_t     out_side,
	output logic [PASS_BITS-1:0]     out_pass,
	output logic [rdmp_pkg::Q_BITS:0] quo_row,
	output logic [rdmp_pkg::Q_BITS:0] ceil_row,
	output logic [rdmp_pkg::Q_BITS:0] quo_col,
	output logic [rdmp_pkg::Q_BITS:0] ceil_col
);
	import rdmp_pkg::*;

	localparam int WIDE_BITS = DEN_BITS + Q_BITS;
	localparam logic [Q_BITS:0] Q_SAT = {1'b1, {Q_BITS{1'b0}}};

	// index 0 is the input, index s holds the registers after stage s
	logic                 valid_s   [0:DIV_STAGES];
	rdmp_side_t           side_s    [0:DIV_STAGES];
	logic [PASS_BITS-1:0] pass_s    [0:DIV_STAGES];
	logic [DEN_BITS-1:0]  den_s     [0:DIV_STAGES];
	logic [NUM_BITS-1:0]  rem_row_s [0:DIV_STAGES];
	logic [NUM_BITS-1:0]  rem_col_s [0:DIV_STAGES];
	logic [Q_BITS-1:0]    quo_row_s [0:DIV_STAGES];
	logic [Q_BITS-1:0]    quo_col_s [0:DIV_STAGES];
	logic                 ovf_row_s [0:DIV_STAGES];
	logic                 ovf_col_s [0:DIV_STAGES];

	assign valid_s[0]   = in_valid;
	assign side_s[0]    = in_side;
	assign pass_s[0]    = in_pass;
	assign den_s[0]     = den;
	assign rem_row_s[0] = num_row;
	assign rem_col_s[0] = num_col;
	assign quo_row_s[0] = '0;
	assign quo_col_s[0] = '0;
	// quotient of 2^Q_BITS or more
	assign ovf_row_s[0] = WIDE_BITS'(num_row) >= (WIDE_BITS'(den) << Q_BITS);
	assign ovf_col_s[0] = WIDE_BITS'(num_col) >= (WIDE_BITS'(den) << Q_BITS);

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
		logic [NUM_BITS-1:0] rem_row_nxt;
		logic [NUM_BITS-1:0] rem_col_nxt;
		logic [Q_BITS-1:0]   quo_row_nxt;
		logic [Q_BITS-1:0]   quo_col_nxt;

		always_comb begin
			logic [WIDE_BITS-1:0] sub;
			rem_row_nxt = rem_row_s[s];
			rem_col_nxt = rem_col_s[s];
			quo_row_nxt = quo_row_s[s];
			quo_col_nxt = quo_col_s[s];
			for (int t = 0; t < DIV_STEPS; t++) begin
				sub = WIDE_BITS'(den_s[s]) << (Q_BITS - 1 - s * DIV_STEPS - t);
				if (WIDE_BITS'(rem_row_nxt) >= sub) begin
					rem_row_nxt = rem_row_nxt - sub[NUM_BITS-1:0];
					quo_row_nxt = {quo_row_nxt[Q_BITS-2:0], 1'b1};
				end else begin
					quo_row_nxt = {quo_row_nxt[Q_BITS-2:0], 1'b0};
				end
				if (WIDE_BITS'(rem_col_nxt) >= sub) begin
					rem_col_nxt = rem_col_nxt - sub[NUM_BITS-1:0];
					quo_col_nxt = {quo_col_nxt[Q_BITS-2:0], 1'b1};
				end else begin
					quo_col_nxt = {quo_col_nxt[Q_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[s+1] <= 1'b0;
			end else begin
				valid_s[s+1] <= valid_s[s];
			end
		end

		always_ff @(posedge clk) begin
			side_s[s+1]    <= side_s[s];
			pass_s[s+1]    <= pass_s[s];
			den_s[s+1]     <= den_s[s];
			rem_row_s[s+1] <= rem_row_nxt;
			rem_col_s[s+1] <= rem_col_nxt;
			quo_row_s[s+1] <= quo_row_nxt;
			quo_col_s[s+1] <= quo_col_nxt;
			ovf_row_s[s+1] <= ovf_row_s[s];
			ovf_col_s[s+1] <= ovf_col_s[s];
		end
	end

	assign out_valid = valid_s[DIV_STAGES];
	assign out_side  = side_s[DIV_STAGES];
	assign out_pass  = pass_s[DIV_STAGES];

	always_comb begin
		if (ovf_row_s[DIV_STAGES]) begin
			quo_row  = Q_SAT;
			ceil_row = Q_SAT;
		end else begin
			quo_row  = {1'b0, quo_row_s[DIV_STAGES]};
			ceil_row = {1'b0, quo_row_s[DIV_STAGES]} + (Q_BITS+1)'(|rem_row_s[DIV_STAGES]);
		end
		if (ovf_col_s[DIV_STAGES]) begin
			quo_col  = Q_SAT;
			ceil_col = Q_SAT;
		end else begin
			quo_col  = {1'b0, quo_col_s[DIV_STAGES]};
			ceil_col = {1'b0, quo_col_s[DIV_STAGES]} + (Q_BITS+1)'(|rem_col_s[DIV_STAGES]);
		end
	end

endmodule

// ----- sv/rdmp_check.sv -----
// Port-level checks of the radial distortion point mapper, bound to its top level.
module rdmp_check #(
	parameter int COORD_BITS = rdmp_pkg::COORD_BITS_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic [COORD_BITS-1:0]                 pixel_row,
	input logic [COORD_BITS-1:0]                 pixel_col,
	input logic                                  done,
	input logic signed [rdmp_pkg::DEST_BITS-1:0] dest_row,
	input logic signed [rdmp_pkg::DEST_BITS-1:0] dest_col,
	input logic [COORD_BITS-1:0]                 src_row_value,
	input logic [COORD_BITS-1:0]                 src_col_value,
	input logic                                  in_frame
);
	import rdmp_pkg::*;

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted beat gave no result");

	a_beat_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted beat");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (src_row_value == $past(pixel_row, LATENCY))
			&& (src_col_value == $past(pixel_col, LATENCY)))
		else $error("source coordinates out of step");

	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(done && in_frame) |-> (!dest_row[DEST_BITS-1] && !dest_col[DEST_BITS-1]))
		else $error("in_frame with negative destination");

endmodule

bind radial_distortion_map_point_unit rdmp_check #(
	.COORD_BITS (COORD_BITS)
) u_rdmp_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.pixel_row     (pixel_row),
	.pixel_col     (pixel_col),
	.done          (done),
	.dest_row      (dest_row),
	.dest_col      (dest_col),
	.src_row_value (src_row_value),
	.src_col_value (src_col_value),
	.in_frame      (in_frame)
);
